[sv/wheel_sync_pid_drive_unit_macros.svh]
// ----------------------------------------------------------------------------
// Wheel sync drive assertion macros
// Shared concurrent assertion forms for the drive controller RTL.
// ----------------------------------------------------------------------------
`ifndef WHEEL_SYNC_PID_DRIVE_UNIT_MACROS_SVH
`define WHEEL_SYNC_PID_DRIVE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("wheel sync drive: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WSD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("wheel sync drive: next-cycle check failed");

`endif

[sv/wsd_pkg.sv]
// ----------------------------------------------------------------------------
// Wheel sync drive package
// Widths, register indexes and shared bundle types of the drive controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

    // Fixed field widths.
    localparam int ENC_PORT_W   = 32;
    localparam int TARGET_W     = 31;
    localparam int POWER_W      = 8;
    localparam int GAIN_W       = 16;
    localparam int DBAND_W      = 8;
    localparam int LIM_W        = 16;
    localparam int SUM_W        = 17;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 31;

    // Design constants.
    localparam int GAIN_FRAC_BITS = 12;
    localparam int ENC_WIDTH      = 32;

    // Derived datapath widths.
    localparam int MAG_W  = ENC_WIDTH;
    localparam int CMP_W  = (MAG_W > TARGET_W) ? MAG_W : TARGET_W;
    localparam int ERR_W  = ENC_WIDTH + 1;
    localparam int DLT_W  = ERR_W + 1;
    localparam int PE_W   = GAIN_W + 1 + ERR_W;
    localparam int PI_W   = GAIN_W + 1 + SUM_W;
    localparam int PD_W   = GAIN_W + 1 + DLT_W;
    localparam int ACC_W  = PD_W + 2;

    // Reset values of the configuration registers.
    localparam logic [TARGET_W-1:0] TARGET_RST = TARGET_W'(22090);
    localparam logic [POWER_W-1:0]  BASE_RST   = POWER_W'(70);
    localparam logic [GAIN_W-1:0]   GAIN_P_RST = GAIN_W'(1638);
    localparam logic [GAIN_W-1:0]   GAIN_I_RST = GAIN_W'(41);
    localparam logic [GAIN_W-1:0]   GAIN_D_RST = GAIN_W'(1638);
    localparam logic [DBAND_W-1:0]  DBAND_RST  = DBAND_W'(3);
    localparam logic [LIM_W-1:0]    LIM_RST    = LIM_W'(100);

    // Motor power saturation limit.
    localparam int POWER_LIMIT = 100;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TARGET    = 3'd0,
        REG_BASE      = 3'd1,
        REG_GAIN_P    = 3'd2,
        REG_GAIN_I    = 3'd3,
        REG_GAIN_D    = 3'd4,
        REG_DEAD_BAND = 3'd5,
        REG_INT_LIM   = 3'd6
    } cfg_addr_t;

    // Current configuration.
    typedef struct packed {
        logic [TARGET_W-1:0]       target;
        logic signed [POWER_W-1:0] base;
        logic [GAIN_W-1:0]         gain_p;
        logic [GAIN_W-1:0]         gain_i;
        logic [GAIN_W-1:0]         gain_d;
        logic [DBAND_W-1:0]        dead_band;
        logic [LIM_W-1:0]          int_lim;
    } cfg_t;

    // Error stage result handed to the gain stage.
    typedef struct packed {
        logic                    done;
        logic signed [ERR_W-1:0] err;
        logic signed [SUM_W-1:0] sum;
        logic signed [DLT_W-1:0] delta;
    } err_t;

endpackage

`default_nettype wire

[sv/wsd_err_stage.sv]
// ----------------------------------------------------------------------------
// Wheel sync drive error stage
// Target check, wheel error with deadband, clamped integral and derivative,
// plus the controller history registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "wheel_sync_pid_drive_unit_macros.svh"

module wsd_err_stage
    import wsd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  ld_en,
    input  wire logic                  in_valid,
    input  wire logic                  in_start,
    input  wire logic [ENC_PORT_W-1:0] in_enc_b,
    input  wire logic [ENC_PORT_W-1:0] in_enc_c,
    input  wire cfg_t                  cfg,
    output err_t                       res
);

    // Magnitude of an encoder count; the most negative count maps exactly.
    function automatic logic [MAG_W-1:0] enc_mag(input logic signed [ENC_WIDTH-1:0] x);
        logic [MAG_W-1:0] m;
        m = x[ENC_WIDTH-1] ? MAG_W'(~x + 1'b1) : MAG_W'(x);
        return m;
    endfunction

    logic signed [ENC_WIDTH-1:0] enc_b;
    logic signed [ENC_WIDTH-1:0] enc_c;
    logic                        done;
    logic signed [ERR_W-1:0]     err_raw;
    logic [ERR_W-1:0]            err_mag;
    logic signed [ERR_W-1:0]     err;
    logic signed [SUM_W-1:0]     sum_old;
    logic signed [ERR_W-1:0]     prev_old;
    logic signed [DLT_W-1:0]     sum_raw;
    logic signed [DLT_W-1:0]     lim_s;
    logic signed [DLT_W-1:0]     sum_clamp;
    logic signed [DLT_W-1:0]     delta;

    logic signed [SUM_W-1:0]     sum_reg;
    logic signed [SUM_W-1:0]     sum_next;
    logic signed [ERR_W-1:0]     prev_reg;
    logic signed [ERR_W-1:0]     prev_next;
    err_t                        res_reg;

    // The encoders are taken from their low bits.
    assign enc_b = $signed(in_enc_b[ENC_WIDTH-1:0]);
    assign enc_c = $signed(in_enc_c[ENC_WIDTH-1:0]);

    // Stop once either wheel has reached the target magnitude.
    always_comb begin
        done = (CMP_W'(enc_mag(enc_b)) >= CMP_W'(cfg.target)) ||
               (CMP_W'(enc_mag(enc_c)) >= CMP_W'(cfg.target));
    end

    // Wheel error with the deadband applied.
    always_comb begin
        err_raw = $signed({enc_b[ENC_WIDTH-1], enc_b}) - $signed({enc_c[ENC_WIDTH-1], enc_c});
        err_mag = err_raw[ERR_W-1] ? ERR_W'(~err_raw + 1'b1) : ERR_W'(err_raw);
        if (err_mag < ERR_W'(cfg.dead_band)) begin
            err = '0;
        end else begin
            err = err_raw;
        end
    end

    // Integral with symmetric clamp, and derivative against the last error.
    always_comb begin
        sum_old  = in_start ? '0 : sum_reg;
        prev_old = in_start ? '0 : prev_reg;
        sum_raw  = $signed({{(DLT_W-SUM_W){sum_old[SUM_W-1]}}, sum_old}) +
                   $signed({err[ERR_W-1], err});
        lim_s    = $signed({{(DLT_W-LIM_W){1'b0}}, cfg.int_lim});
        if (sum_raw > lim_s) begin
            sum_clamp = lim_s;
        end else if (sum_raw < -lim_s) begin
            sum_clamp = -lim_s;
        end else begin
            sum_clamp = sum_raw;
        end
        delta = $signed({err[ERR_W-1], err}) - $signed({prev_old[ERR_W-1], prev_old});
    end

    // History update: a done tick only honors the start clear.
    always_comb begin
        sum_next  = sum_reg;
        prev_next = prev_reg;
        if (ld_en && in_valid) begin
            if (done) begin
                sum_next  = sum_old;
                prev_next = prev_old;
            end else begin
                sum_next  = sum_clamp[SUM_W-1:0];
                prev_next = err;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            prev_reg <= '0;
        end else begin
            sum_reg  <= sum_next;
            prev_reg <= prev_next;
        end
    end

    // Stage result register.
    always_ff @(posedge aclk) begin
        if (ld_en) begin
            res_reg.done  <= done;
            res_reg.err   <= err;
            res_reg.sum   <= sum_clamp[SUM_W-1:0];
            res_reg.delta <= delta;
        end
    end

    assign res = res_reg;

    // A done tick without start leaves the history alone.
    `WSD_ASSERT_NXT(a_done_keeps_hist, aclk, aresetn,
        ld_en && in_valid && done && !in_start,
        $stable(sum_reg) && $stable(prev_reg))

    // A done tick with start leaves a cleared history.
    `WSD_ASSERT_NXT(a_done_start_clears, aclk, aresetn,
        ld_en && in_valid && done && in_start,
        (sum_reg == '0) && (prev_reg == '0))

endmodule

`default_nettype wire

[sv/wheel_sync_pid_drive_unit.sv]
// ----------------------------------------------------------------------------
// Wheel sync PID drive unit
// Two-wheel straight-line drive controller with PID correction.
// ----------------------------------------------------------------------------
// The unit takes one control tick per clock cycle while the output is not
// stalled, and returns one result per tick. Each accepted tick passes
// through four register stages in order: the input register, the error stage
// (where the integral and previous-error history close their loop), the gain
// multiplier stage and the output register with rounding toward zero and
// power saturation. Configuration writes take effect on the next cycle and
// must only be made while no tick is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "wheel_sync_pid_drive_unit_macros.svh"

module wheel_sync_pid_drive_unit
    import wsd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration write port.
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // Encoder tick input.
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_start_req,
    input  wire logic [ENC_PORT_W-1:0] s_enc_b,
    input  wire logic [ENC_PORT_W-1:0] s_enc_c,
    // Motor power output.
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [POWER_W-1:0]         m_power_b,
    output logic [POWER_W-1:0]         m_power_c,
    output logic                       m_done_res
);

    // Saturate a wide power value to the motor range.
    function automatic logic [POWER_W-1:0] sat_power(input logic signed [ACC_W-1:0] x);
        logic [POWER_W-1:0] r;
        if (x > ACC_W'(POWER_LIMIT)) begin
            r = POWER_W'(POWER_LIMIT);
        end else if (x < -ACC_W'(POWER_LIMIT)) begin
            r = POWER_W'(-POWER_LIMIT);
        end else begin
            r = x[POWER_W-1:0];
        end
        return r;
    endfunction

    localparam logic [ACC_W-1:0] FRAC_MASK = ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

    cfg_t                     cfg_reg;
    cfg_t                     cfg_next;

    logic                     v1_reg;
    logic                     v2_reg;
    logic                     v3_reg;
    logic                     v4_reg;
    logic                     adv1;
    logic                     adv2;
    logic                     adv3;
    logic                     adv4;

    logic                     start_reg;
    logic [ENC_PORT_W-1:0]    enc_b_reg;
    logic [ENC_PORT_W-1:0]    enc_c_reg;
    err_t                     err_res;

    logic                     done3_reg;
    logic signed [PE_W-1:0]   prod_p_reg;
    logic signed [PI_W-1:0]   prod_i_reg;
    logic signed [PD_W-1:0]   prod_d_reg;

    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_adj;
    logic signed [ACC_W-1:0]  corr;
    logic signed [ACC_W-1:0]  base_ext;
    logic signed [ACC_W-1:0]  pb_wide;
    logic signed [ACC_W-1:0]  pc_wide;

    logic [POWER_W-1:0]       power_b_reg;
    logic [POWER_W-1:0]       power_c_reg;
    logic                     done_res_reg;

    // Configuration register decode; unknown indexes are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr_t'(cfg_addr))
                REG_TARGET:    cfg_next.target    = cfg_wdata[TARGET_W-1:0];
                REG_BASE:      cfg_next.base      = $signed(cfg_wdata[POWER_W-1:0]);
                REG_GAIN_P:    cfg_next.gain_p    = cfg_wdata[GAIN_W-1:0];
                REG_GAIN_I:    cfg_next.gain_i    = cfg_wdata[GAIN_W-1:0];
                REG_GAIN_D:    cfg_next.gain_d    = cfg_wdata[GAIN_W-1:0];
                REG_DEAD_BAND: cfg_next.dead_band = cfg_wdata[DBAND_W-1:0];
                REG_INT_LIM:   cfg_next.int_lim   = cfg_wdata[LIM_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target    <= TARGET_RST;
            cfg_reg.base      <= BASE_RST;
            cfg_reg.gain_p    <= GAIN_P_RST;
            cfg_reg.gain_i    <= GAIN_I_RST;
            cfg_reg.gain_d    <= GAIN_D_RST;
            cfg_reg.dead_band <= DBAND_RST;
            cfg_reg.int_lim   <= LIM_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Pipeline advance: a stage loads when it is empty or its content moves on.
    assign adv4    = !v4_reg || m_ready;
    assign adv3    = !v3_reg || adv4;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= s_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (adv3) begin
                v3_reg <= v2_reg;
            end
            if (adv4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Input register: holds the accepted transaction.
    always_ff @(posedge aclk) begin
        if (adv1) begin
            start_reg <= s_start_req;
            enc_b_reg <= s_enc_b;
            enc_c_reg <= s_enc_c;
        end
    end

    // Error stage with the controller history.
    wsd_err_stage u_err (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ld_en    (adv2),
        .in_valid (v1_reg),
        .in_start (start_reg),
        .in_enc_b (enc_b_reg),
        .in_enc_c (enc_c_reg),
        .cfg      (cfg_reg),
        .res      (err_res)
    );

    // Gain stage: one registered multiplier per term.
    always_ff @(posedge aclk) begin
        if (adv3) begin
            done3_reg  <= err_res.done;
            prod_p_reg <= $signed({1'b0, cfg_reg.gain_p}) * err_res.err;
            prod_i_reg <= $signed({1'b0, cfg_reg.gain_i}) * err_res.sum;
            prod_d_reg <= $signed({1'b0, cfg_reg.gain_d}) * err_res.delta;
        end
    end

    // Sum the terms, drop the fraction toward zero and apply to both motors.
    always_comb begin
        acc = $signed({{(ACC_W-PE_W){prod_p_reg[PE_W-1]}}, prod_p_reg}) +
              $signed({{(ACC_W-PI_W){prod_i_reg[PI_W-1]}}, prod_i_reg}) +
              $signed({{(ACC_W-PD_W){prod_d_reg[PD_W-1]}}, prod_d_reg});
        acc_adj  = acc[ACC_W-1] ? (acc + $signed(FRAC_MASK)) : acc;
        corr     = acc_adj >>> GAIN_FRAC_BITS;
        base_ext = $signed({{(ACC_W-POWER_W){cfg_reg.base[POWER_W-1]}}, cfg_reg.base});
        pb_wide  = base_ext - corr;
        pc_wide  = base_ext + corr;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (adv4) begin
            if (done3_reg) begin
                power_b_reg <= '0;
                power_c_reg <= '0;
            end else begin
                power_b_reg <= sat_power(pb_wide);
                power_c_reg <= sat_power(pc_wide);
            end
            done_res_reg <= done3_reg;
        end
    end

    assign m_valid    = v4_reg;
    assign m_power_b  = power_b_reg;
    assign m_power_c  = power_c_reg;
    assign m_done_res = done_res_reg;

    // A done result always carries stopped motors.
    `WSD_ASSERT_IMP(a_done_zero_power, aclk, aresetn,
        m_valid && m_done_res,
        (m_power_b == '0) && (m_power_c == '0))

    // Delivered powers stay within the motor range.
    `WSD_ASSERT_IMP(a_power_range, aclk, aresetn,
        m_valid,
        ($signed(m_power_b) <= 8'sd100) && ($signed(m_power_b) >= -8'sd100) &&
        ($signed(m_power_c) <= 8'sd100) && ($signed(m_power_c) >= -8'sd100))

    // With the output register empty the whole pipe can move, so input is open.
    `WSD_ASSERT_IMP(a_ready_when_drained, aclk, aresetn,
        !m_valid,
        s_ready)

endmodule

`default_nettype wire

[verif/tb_wheel_sync_pid_drive_unit.sv]
// ----------------------------------------------------------------------------
// Wheel sync PID drive unit testbench
// Drives encoder ticks and register settings into the drive controller and
// compares every motor power result with a cycle-free model of the PID law.
// It starts with directed corner ticks, then runs random well-formed drive
// runs mixed with noise under several register settings. Both handshakes are
// throttled at random, and there is one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_wheel_sync_pid_drive_unit;
    import wsd_pkg::*;

    // Register index that the block does not decode.
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

    // One expected motor power transaction.
    typedef struct packed {
        logic [POWER_W-1:0] power_b;
        logic [POWER_W-1:0] power_c;
        logic               done;
    } drive_out_t;

    // Scoreboard: mirrors the registers and the PID history, and holds the
    // motor powers that accepted ticks must produce, oldest first.
    class power_scoreboard;
        cfg_t       cfg;
        longint     last_err;
        longint     err_acc;
        drive_out_t power_q[$];
        int         n_err;
        int         n_seen;
        int         n_done;

        function new();
            cfg.target    = TARGET_RST;
            cfg.base      = BASE_RST;
            cfg.gain_p    = GAIN_P_RST;
            cfg.gain_i    = GAIN_I_RST;
            cfg.gain_d    = GAIN_D_RST;
            cfg.dead_band = DBAND_RST;
            cfg.int_lim   = LIM_RST;
            last_err      = 0;
            err_acc       = 0;
            n_err         = 0;
            n_seen        = 0;
            n_done        = 0;
        endfunction

        static function longint mag64(longint x);
            return (x < 0) ? -x : x;
        endfunction

        static function longint clip_power(longint x);
            if (x > POWER_LIMIT) return POWER_LIMIT;
            if (x < -POWER_LIMIT) return -POWER_LIMIT;
            return x;
        endfunction

        // Register write as seen on the configuration port.
        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TARGET:    cfg.target    = data[TARGET_W-1:0];
                REG_BASE:      cfg.base      = data[POWER_W-1:0];
                REG_GAIN_P:    cfg.gain_p    = data[GAIN_W-1:0];
                REG_GAIN_I:    cfg.gain_i    = data[GAIN_W-1:0];
                REG_GAIN_D:    cfg.gain_d    = data[GAIN_W-1:0];
                REG_DEAD_BAND: cfg.dead_band = data[DBAND_W-1:0];
                REG_INT_LIM:   cfg.int_lim   = data[LIM_W-1:0];
                default: ;
            endcase
        endfunction

        // Predict the motor powers of one accepted tick.
        function void note_tick(logic start, logic [ENC_PORT_W-1:0] b_raw,
                                logic [ENC_PORT_W-1:0] c_raw);
            longint     b, c, e, delta, lim, acc, corr, tgt;
            drive_out_t r;
            if (start) begin
                last_err = 0;
                err_acc  = 0;
            end
            b   = longint'($signed(b_raw));
            c   = longint'($signed(c_raw));
            tgt = longint'(cfg.target);
            if (mag64(b) >= tgt || mag64(c) >= tgt) begin
                // Target reached: motors off, history kept.
                r.power_b = '0;
                r.power_c = '0;
                r.done    = 1'b1;
                n_done++;
            end else begin
                e = b - c;
                if (mag64(e) < longint'(cfg.dead_band)) e = 0;
                lim = longint'(cfg.int_lim);
                err_acc += e;
                if (err_acc > lim) err_acc = lim;
                if (err_acc < -lim) err_acc = -lim;
                delta = e - last_err;
                acc = longint'(cfg.gain_p) * e + longint'(cfg.gain_i) * err_acc
                    + longint'(cfg.gain_d) * delta;
                // Signed division truncates toward zero.
                corr = acc / (longint'(1) << GAIN_FRAC_BITS);
                r.power_b = POWER_W'(clip_power(longint'($signed(cfg.base)) - corr));
                r.power_c = POWER_W'(clip_power(longint'($signed(cfg.base)) + corr));
                r.done    = 1'b0;
                last_err  = e;
            end
            power_q.push_back(r);
        endfunction

        // Compare one output transaction with the oldest prediction.
        function void check_power(logic [POWER_W-1:0] pb, logic [POWER_W-1:0] pc, logic dn);
            drive_out_t w;
            if (power_q.size() == 0) begin
                n_err++;
                $display("%0t: result with no tick pending: power_b %0d power_c %0d done %0b",
                         $time, $signed(pb), $signed(pc), dn);
                return;
            end
            w = power_q.pop_front();
            n_seen++;
            if (pb !== w.power_b) begin
                n_err++;
                $display("%0t: power_b expected %0d, actual %0d",
                         $time, $signed(w.power_b), $signed(pb));
            end
            if (pc !== w.power_c) begin
                n_err++;
                $display("%0t: power_c expected %0d, actual %0d",
                         $time, $signed(w.power_c), $signed(pc));
            end
            if (dn !== w.done) begin
                n_err++;
                $display("%0t: done_res expected %0b, actual %0b", $time, w.done, dn);
            end
        endfunction
    endclass

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic                  s_start_req = 1'b0;
    logic [ENC_PORT_W-1:0] s_enc_b     = '0;
    logic [ENC_PORT_W-1:0] s_enc_c     = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [POWER_W-1:0]    m_power_b;
    logic [POWER_W-1:0]    m_power_c;
    logic                  m_done_res;

    power_scoreboard tracker = new();

    // Throttling controls shared by the drivers.
    int     send_idle  = 25;
    int     recv_idle  = 73;
    int     hold_left  = 0;
    int     n_settings = 0;

    // State of the well-formed drive run generator.
    longint odo        = 0;
    longint drift      = 0;
    bit     new_run    = 1'b1;
    bit     dir_neg    = 1'b0;

    wheel_sync_pid_drive_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_start_req (s_start_req),
        .s_enc_b     (s_enc_b),
        .s_enc_c     (s_enc_c),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_power_b   (m_power_b),
        .m_power_c   (m_power_c),
        .m_done_res  (m_done_res)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Monitor: mirror register writes, record accepted ticks, check results.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) tracker.write_reg(cfg_addr, cfg_wdata);
            if (s_valid && s_ready) tracker.note_tick(s_start_req, s_enc_b, s_enc_c);
            if (m_valid && m_ready) tracker.check_power(m_power_b, m_power_c, m_done_res);
        end
    end

    // Receiver: random back-pressure, plus a long hold-off when requested.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    // Offer one tick, with random idle cycles first, and wait for acceptance.
    task automatic send_tick(input logic st, input logic [ENC_PORT_W-1:0] b,
                             input logic [ENC_PORT_W-1:0] c);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_start_req <= st;
        s_enc_b     <= b;
        s_enc_c     <= c;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and let every pending result drain out of the pipeline.
    task automatic settle();
        @(negedge aclk) s_valid <= 1'b0;
        while (tracker.power_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_one(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
    endtask

    // Write all registers; unused upper data bits carry random junk.
    task automatic load_settings(input logic [TARGET_W-1:0] tgt,
                                 input logic [POWER_W-1:0] base,
                                 input logic [GAIN_W-1:0] gp,
                                 input logic [GAIN_W-1:0] gi,
                                 input logic [GAIN_W-1:0] gd,
                                 input logic [DBAND_W-1:0] db,
                                 input logic [LIM_W-1:0] lim);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_one(REG_TARGET, tgt);
        write_one(REG_BASE, {junk[CFG_DATA_W-1:POWER_W], base});
        write_one(REG_GAIN_P, {junk[CFG_DATA_W-1:GAIN_W], gp});
        write_one(REG_GAIN_I, {junk[CFG_DATA_W-1:GAIN_W], gi});
        write_one(REG_GAIN_D, {junk[CFG_DATA_W-1:GAIN_W], gd});
        write_one(REG_DEAD_BAND, {junk[CFG_DATA_W-1:DBAND_W], db});
        write_one(REG_INT_LIM, {junk[CFG_DATA_W-1:LIM_W], lim});
        write_one(REG_UNUSED, junk);
        @(negedge aclk) cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // Encoder values at the interesting boundaries.
    function automatic logic [ENC_PORT_W-1:0] pick_edge(longint tgt);
        case ($urandom_range(0, 8))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4: return ENC_PORT_W'(tgt);
            5: return ENC_PORT_W'(tgt - 1);
            6: return ENC_PORT_W'(-tgt);
            7: return ENC_PORT_W'(1 - tgt);
            default: return ENC_PORT_W'(tgt + 1);
        endcase
    endfunction

    // Mostly drive runs that start with a start request and creep toward the
    // target with a wandering wheel difference; the rest is noise.
    task automatic next_random_tick(output logic st, output logic [ENC_PORT_W-1:0] b,
                                    output logic [ENC_PORT_W-1:0] c);
        int     mode;
        longint tgt, span, dstep;
        mode = $urandom_range(0, 99);
        tgt  = longint'(tracker.cfg.target);
        if (mode < 65) begin
            span  = tgt / 30 + 2;
            dstep = longint'(tracker.cfg.dead_band) + 20;
            if (new_run) begin
                st      = 1'b1;
                odo     = 0;
                drift   = 0;
                dir_neg = ($urandom_range(0, 3) == 0);
                new_run = 1'b0;
            end else begin
                st = 1'b0;
            end
            odo   += longint'($urandom_range(0, 32'(span)));
            drift += longint'($urandom_range(0, 32'(2 * dstep))) - dstep;
            if (drift > 4000 || drift < -4000) drift = drift / 2;
            b = ENC_PORT_W'(dir_neg ? -(odo + drift) : (odo + drift));
            c = ENC_PORT_W'(dir_neg ? -odo : odo);
            if (odo >= tgt && $urandom_range(0, 1) == 1) new_run = 1'b1;
        end else if (mode < 85) begin
            st = 1'($urandom);
            b  = $urandom;
            c  = $urandom;
        end else begin
            st = ($urandom_range(0, 9) == 0);
            b  = pick_edge(tgt);
            c  = pick_edge(tgt);
        end
    endtask

    // Main sequence.
    initial begin
        int                    k;
        int                    n;
        logic                  st;
        logic [ENC_PORT_W-1:0] b;
        logic [ENC_PORT_W-1:0] c;

        repeat (2) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Directed ticks under the reset values: dead band, integral clamp,
        // target reached on either wheel, start request on a done tick and
        // the most negative count.
        send_tick(1'b1, 32'sd0, 32'sd0);
        send_tick(1'b0, 32'sd10, 32'sd0);
        send_tick(1'b0, 32'sd12, 32'sd10);
        send_tick(1'b0, -32'sd3, 32'sd0);
        send_tick(1'b0, 32'sd0, 32'sd200);
        send_tick(1'b0, 32'sd1000, -32'sd1000);
        send_tick(1'b0, 32'sd1000, -32'sd1000);
        send_tick(1'b0, -32'sd1000, 32'sd1000);
        send_tick(1'b0, 32'sd22089, -32'sd22089);
        send_tick(1'b0, 32'sd22090, 32'sd0);
        send_tick(1'b0, 32'sd0, -32'sd22090);
        send_tick(1'b1, 32'sd22090, 32'sd5);
        send_tick(1'b0, 32'h8000_0000, 32'sd0);
        send_tick(1'b0, 32'h7fff_ffff, 32'h8000_0000);
        send_tick(1'b1, 32'sd5, 32'sd5);

        // Largest target and gains: huge corrections, base above range.
        settle();
        load_settings(31'h7fff_ffff, 8'sd127, 16'hffff, 16'hffff, 16'hffff, 8'd0, 16'hffff);
        send_tick(1'b0, 32'h7fff_fff0, 32'h8000_0010);
        send_tick(1'b0, 32'h8000_0010, 32'h7fff_fff0);
        send_tick(1'b0, 32'h7fff_fffe, 32'h8000_0001);
        send_tick(1'b1, 32'h7fff_fffe, 32'h7fff_fffe);

        // Zero target: every tick is done.
        settle();
        load_settings(31'd0, 8'h80, 16'd0, 16'd0, 16'd0, 8'hff, 16'd0);
        send_tick(1'b0, 32'sd0, 32'sd0);
        send_tick(1'b0, 32'sd5, 32'sd1);

        // Zero integral limit with the widest dead band.
        settle();
        load_settings(31'd1000, -8'sd100, 16'd4096, 16'd4096, 16'd0, 8'hff, 16'd0);
        send_tick(1'b0, 32'sd300, 32'sd0);
        send_tick(1'b0, 32'sd100, 32'sd0);
        send_tick(1'b0, -32'sd254, 32'sd0);

        // Random part, one block of ticks per register setting.
        for (k = 0; k < 8; k++) begin
            settle();
            if (k < 3) begin
                send_idle = 25;
                recv_idle = 73;
            end else if (k < 6) begin
                send_idle = 73;
                recv_idle = 25;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            case (k)
                0: load_settings(TARGET_RST, BASE_RST, GAIN_P_RST, GAIN_I_RST, GAIN_D_RST,
                                 DBAND_RST, LIM_RST);
                1: load_settings(31'($urandom_range(200, 200000)),
                                 8'(int'($urandom_range(0, 200)) - 100),
                                 16'($urandom), 16'($urandom), 16'($urandom),
                                 8'($urandom), 16'($urandom));
                2: load_settings(31'h7fff_ffff, 8'sd100, 16'hffff, 16'hffff, 16'hffff,
                                 8'hff, 16'hffff);
                3: load_settings(31'd3000, -8'sd100, 16'd0, 16'd0, 16'hffff, 8'd0, 16'd0);
                4: load_settings(31'($urandom), 8'($urandom),
                                 16'($urandom_range(0, 8192)), 16'($urandom_range(0, 8192)),
                                 16'($urandom_range(0, 8192)), 8'($urandom), 16'($urandom));
                5: load_settings(31'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 8'($urandom), 16'($urandom));
                6: load_settings(31'd5000, 8'sd50, 16'd4096, 16'd200, 16'd2048, 8'd10,
                                 16'd500);
                default: load_settings(31'($urandom_range(0, 60000)),
                                       8'(int'($urandom_range(0, 200)) - 100),
                                       16'($urandom), 16'($urandom), 16'($urandom),
                                       8'($urandom_range(0, 40)),
                                       16'($urandom_range(0, 2000)));
            endcase
            new_run = 1'b1;
            for (n = 0; n < 140; n++) begin
                // Long output stall while ticks keep coming, to fill the pipe.
                if (k == 0 && n == 40) hold_left = 300;
                next_random_tick(st, b, c);
                send_tick(st, b, c);
            end
        end

        settle();
        repeat (12) @(posedge aclk);

        $display("Checked %0d motor power results over %0d register settings.",
                 tracker.n_seen, n_settings);
        $display("%0d of them were target-reached ticks; one output stall lasted 300 cycles.",
                 tracker.n_done);
        if (tracker.n_err == 0 && tracker.power_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/wsd_pkg.sv
sv/wsd_err_stage.sv
sv/wheel_sync_pid_drive_unit.sv
verif/tb_wheel_sync_pid_drive_unit.sv
